@@ rtl/svpwm_pkg.sv @@
package svpwm_pkg;

    localparam int PC_W = 4;

    localparam logic [15:0] ONE_Q15     = 16'h8000;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [15:0] RECIP3      = 16'd43691;
    localparam int          RECIP_SHIFT = 17;
    localparam int          Q15_SHIFT   = 15;

    localparam logic [14:0] PHASE_STEP_RST = 15'd328;
    localparam logic [15:0] MOD_INDEX_RST  = 16'd28378;
    localparam logic [15:0] PWM_PERIOD_RST = 16'd7500;

    localparam logic [1:0] REG_PHASE_STEP = 2'd0;
    localparam logic [1:0] REG_MOD_INDEX  = 2'd1;
    localparam logic [1:0] REG_PWM_PERIOD = 2'd2;

    // multiplier operand a
    localparam logic [2:0] A_THETA   = 3'd0;
    localparam logic [2:0] A_COTHETA = 3'd1;
    localparam logic [2:0] A_QUOT    = 3'd2;
    localparam logic [2:0] A_MOD     = 3'd3;
    localparam logic [2:0] A_PERIOD  = 3'd4;

    // multiplier operand b
    localparam logic [2:0] B_TWO_D = 3'd0;
    localparam logic [2:0] B_RECIP = 3'd1;
    localparam logic [2:0] B_SIN   = 3'd2;
    localparam logic [2:0] B_SUB_A = 3'd3;
    localparam logic [2:0] B_SUB_B = 3'd4;
    localparam logic [2:0] B_SUB_C = 3'd5;

    // register write select
    localparam logic [2:0] W_NONE  = 3'd0;
    localparam logic [2:0] W_ANGLE = 3'd1;
    localparam logic [2:0] W_SIN   = 3'd2;
    localparam logic [2:0] W_TB    = 3'd3;
    localparam logic [2:0] W_TA    = 3'd4;
    localparam logic [2:0] W_ON    = 3'd5;
    localparam logic [2:0] W_CA    = 3'd6;
    localparam logic [2:0] W_CB    = 3'd7;

    // sequencing
    localparam logic [1:0] J_NEXT     = 2'd0;
    localparam logic [1:0] J_WAIT_IN  = 2'd1;
    localparam logic [1:0] J_WAIT_OUT = 2'd2;

    typedef struct packed {
        logic [2:0] a_sel;
        logic [2:0] b_sel;
        logic       mul_en;
        logic [2:0] wr;
        logic [1:0] jmp;
    } ctrl_t;

    function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
        ctrl_t c;
        c = '{a_sel: A_THETA, b_sel: B_TWO_D, mul_en: 1'b0, wr: W_NONE, jmp: J_NEXT};
        unique case (pc)
            4'd0:  c.jmp = J_WAIT_IN;
            4'd1:  c.wr = W_ANGLE;
            4'd2:  begin c.a_sel = A_THETA;   c.b_sel = B_TWO_D; c.mul_en = 1'b1; end
            4'd3:  begin c.a_sel = A_QUOT;    c.b_sel = B_RECIP; c.mul_en = 1'b1; end
            4'd4:  c.wr = W_SIN;
            4'd5:  begin c.a_sel = A_MOD;     c.b_sel = B_SIN;   c.mul_en = 1'b1; end
            4'd6:  begin
                c.a_sel = A_COTHETA; c.b_sel = B_TWO_D; c.mul_en = 1'b1; c.wr = W_TB;
            end
            4'd7:  begin c.a_sel = A_QUOT;    c.b_sel = B_RECIP; c.mul_en = 1'b1; end
            4'd8:  c.wr = W_SIN;
            4'd9:  begin c.a_sel = A_MOD;     c.b_sel = B_SIN;   c.mul_en = 1'b1; end
            4'd10: c.wr = W_TA;
            4'd11: c.wr = W_ON;
            4'd12: begin c.a_sel = A_PERIOD;  c.b_sel = B_SUB_A; c.mul_en = 1'b1; end
            4'd13: begin
                c.a_sel = A_PERIOD; c.b_sel = B_SUB_B; c.mul_en = 1'b1; c.wr = W_CA;
            end
            4'd14: begin
                c.a_sel = A_PERIOD; c.b_sel = B_SUB_C; c.mul_en = 1'b1; c.wr = W_CB;
            end
            4'd15: c.jmp = J_WAIT_OUT;
        endcase
        return c;
    endfunction

    // sine of an angle in q2.30 radians, taylor series to x^17, rounded to q1.15
    function automatic logic [15:0] sine_q15(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] r;
        x2 = (x * x) >> 30;
        t  = x;
        s  = x;
        t  = ((t * x2) >> 30) / 64'd6;
        s  = (s >= t) ? s - t : 64'd0;
        t  = ((t * x2) >> 30) / 64'd20;
        s  = s + t;
        t  = ((t * x2) >> 30) / 64'd42;
        s  = (s >= t) ? s - t : 64'd0;
        t  = ((t * x2) >> 30) / 64'd72;
        s  = s + t;
        t  = ((t * x2) >> 30) / 64'd110;
        s  = (s >= t) ? s - t : 64'd0;
        t  = ((t * x2) >> 30) / 64'd156;
        s  = s + t;
        t  = ((t * x2) >> 30) / 64'd210;
        s  = (s >= t) ? s - t : 64'd0;
        t  = ((t * x2) >> 30) / 64'd272;
        s  = s + t;
        r  = (s + 64'd16384) >> 15;
        return (r > 64'd32768) ? ONE_Q15 : r[15:0];
    endfunction

endpackage

@@ rtl/space_vector_pwm_generator_core.sv @@
// Three-phase centered space vector PWM generator. Each accepted word on the
// slave side (bit 0 = tick) optionally advances the phase accumulator by
// phase_step, then a microcoded sequencer drives one shared multiplier through
// a sixteen-step program: sector and in-sector angle, two quarter-wave sine
// lookups, scaling by the saturated modulation index into the active times,
// and three compare values pwm_period*(1-on/Ts). No new word is taken until
// the whole program has run and its result sits in the output register. The
// sequencer holds while it waits for a word and while that register is still
// full and not being taken. Configuration is written through the cfg_we,
// cfg_index and cfg_data ports; the user must do so only while idle, since
// the block itself does not enforce it.
module space_vector_pwm_generator_core #(
    parameter int PHASE_BITS       = 16,
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // tick
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // compare_a, compare_b, compare_c, sector
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int MAW  = (PHASE_BITS + 1 > 17) ? PHASE_BITS + 1 : 17;
    localparam int PW   = MAW + 17;
    localparam int QW   = $clog2(2 * SINE_TABLE_DEPTH + 1);
    localparam int IW   = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int SUMW = ((PHASE_BITS > 15) ? PHASE_BITS : 15) + 1;

    logic [svpwm_pkg::PC_W-1:0] pc_reg, pc_next;
    logic                       out_valid_reg, out_valid_next;
    logic [55:0]                out_data_reg;

    logic [14:0] phase_step_reg;
    logic [15:0] mod_index_reg;
    logic [15:0] pwm_period_reg;
    logic [PHASE_BITS-1:0] phase_reg;

    logic [2:0]            sec_reg;
    logic [PHASE_BITS-1:0] theta_reg;
    logic [PW-1:0]         prod_reg;
    logic [15:0]           sin_reg;
    logic [15:0]           ta_reg, tb_reg;
    logic [15:0]           on_a_reg, on_b_reg, on_c_reg;
    logic [15:0]           ca_reg, cb_reg;

    svpwm_pkg::ctrl_t uc;
    logic             accept;
    logic             load_out;
    logic [SUMW-1:0]  phase_sum;

    logic [PHASE_BITS+2:0] scaled;
    logic [PHASE_BITS:0]   cotheta;
    logic [15:0]           m_sat;
    logic [MAW-1:0]        mul_a;
    logic [16:0]           mul_b;
    logic [PW-1:0]         prod;
    logic [IW-1:0]         idx_raw, idx;
    logic [15:0]           sine_rom [0:SINE_TABLE_DEPTH];

    logic [16:0] sum_ab;
    logic [15:0] tb_fix;
    logic [16:0] t0;
    logic [15:0] h;
    logic [15:0] on_ab, on_a_only, on_b_only;
    logic [15:0] on_a, on_b, on_c;

    for (genvar gi = 0; gi <= SINE_TABLE_DEPTH; gi++) begin : g_sine
        localparam logic [63:0] ANGLE_Q30 =
            (64'(gi) * svpwm_pkg::HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
        localparam logic [15:0] SINE_VAL = svpwm_pkg::sine_q15(ANGLE_Q30);
        assign sine_rom[gi] = SINE_VAL;
    end

    assign uc       = svpwm_pkg::ucode(pc_reg);
    assign s_tready = (uc.jmp == svpwm_pkg::J_WAIT_IN);
    assign accept   = s_tvalid && s_tready;
    assign load_out = (uc.jmp == svpwm_pkg::J_WAIT_OUT) && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign phase_sum = SUMW'(phase_reg) + SUMW'(phase_step_reg);

    always_comb
    begin
        pc_next = pc_reg;
        unique case (uc.jmp)
            svpwm_pkg::J_NEXT:     pc_next = pc_reg + 1'b1;
            svpwm_pkg::J_WAIT_IN:  if (accept) pc_next = pc_reg + 1'b1;
            svpwm_pkg::J_WAIT_OUT: if (load_out) pc_next = '0;
            default:               pc_next = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg         <= '0;
            out_valid_reg  <= 1'b0;
            phase_reg      <= '0;
            phase_step_reg <= svpwm_pkg::PHASE_STEP_RST;
            mod_index_reg  <= svpwm_pkg::MOD_INDEX_RST;
            pwm_period_reg <= svpwm_pkg::PWM_PERIOD_RST;
        end
        else
        begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
            if (accept && s_tdata[0])
                phase_reg <= phase_sum[PHASE_BITS-1:0];
            if (cfg_we)
            begin
                unique case (cfg_index)
                    svpwm_pkg::REG_PHASE_STEP: phase_step_reg <= cfg_data[14:0];
                    svpwm_pkg::REG_MOD_INDEX:  mod_index_reg  <= cfg_data;
                    svpwm_pkg::REG_PWM_PERIOD: pwm_period_reg <= cfg_data;
                    default:                   ;
                endcase
            end
        end
    end

    // datapath
    assign scaled  = (PHASE_BITS + 3)'({phase_reg, 2'b00}) + (PHASE_BITS + 3)'({phase_reg, 1'b0});
    assign cotheta = {1'b1, {PHASE_BITS{1'b0}}} - {1'b0, theta_reg};
    assign m_sat   = (mod_index_reg > svpwm_pkg::ONE_Q15) ? svpwm_pkg::ONE_Q15 : mod_index_reg;

    always_comb
    begin
        unique case (uc.a_sel)
            svpwm_pkg::A_THETA:   mul_a = MAW'(theta_reg);
            svpwm_pkg::A_COTHETA: mul_a = MAW'(cotheta);
            svpwm_pkg::A_QUOT:    mul_a = MAW'(prod_reg[PHASE_BITS +: QW]);
            svpwm_pkg::A_MOD:     mul_a = MAW'(m_sat);
            svpwm_pkg::A_PERIOD:  mul_a = MAW'(pwm_period_reg);
            default:              mul_a = '0;
        endcase
    end

    always_comb
    begin
        unique case (uc.b_sel)
            svpwm_pkg::B_TWO_D: mul_b = 17'(2 * SINE_TABLE_DEPTH);
            svpwm_pkg::B_RECIP: mul_b = 17'(svpwm_pkg::RECIP3);
            svpwm_pkg::B_SIN:   mul_b = 17'(sin_reg);
            svpwm_pkg::B_SUB_A: mul_b = 17'(svpwm_pkg::ONE_Q15) - 17'(on_a_reg);
            svpwm_pkg::B_SUB_B: mul_b = 17'(svpwm_pkg::ONE_Q15) - 17'(on_b_reg);
            svpwm_pkg::B_SUB_C: mul_b = 17'(svpwm_pkg::ONE_Q15) - 17'(on_c_reg);
            default:            mul_b = '0;
        endcase
    end

    assign prod = PW'(mul_a) * PW'(mul_b);

    assign idx_raw = prod_reg[svpwm_pkg::RECIP_SHIFT +: IW];
    assign idx     = (idx_raw > IW'(SINE_TABLE_DEPTH)) ? IW'(SINE_TABLE_DEPTH) : idx_raw;

    // active time overflow trims tb
    assign sum_ab    = {1'b0, ta_reg} + {1'b0, tb_reg};
    assign tb_fix    = (sum_ab > 17'(svpwm_pkg::ONE_Q15)) ?
                       16'(17'(svpwm_pkg::ONE_Q15) - {1'b0, ta_reg}) : tb_reg;
    assign t0        = 17'(svpwm_pkg::ONE_Q15) - {1'b0, ta_reg} - {1'b0, tb_fix};
    assign h         = t0[16:1];
    assign on_ab     = ta_reg + tb_fix + h;
    assign on_a_only = ta_reg + h;
    assign on_b_only = tb_fix + h;

    always_comb
    begin
        case (sec_reg)
            3'd0:    begin on_a = on_ab;     on_b = on_b_only; on_c = h;         end
            3'd1:    begin on_a = on_a_only; on_b = on_ab;     on_c = h;         end
            3'd2:    begin on_a = h;         on_b = on_ab;     on_c = on_b_only; end
            3'd3:    begin on_a = h;         on_b = on_a_only; on_c = on_ab;     end
            3'd4:    begin on_a = on_b_only; on_b = h;         on_c = on_ab;     end
            default: begin on_a = on_ab;     on_b = h;         on_c = on_a_only; end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (uc.mul_en)
            prod_reg <= prod;
        unique case (uc.wr)
            svpwm_pkg::W_ANGLE:
            begin
                sec_reg   <= scaled[PHASE_BITS +: 3];
                theta_reg <= scaled[PHASE_BITS-1:0];
            end
            svpwm_pkg::W_SIN: sin_reg <= sine_rom[idx];
            svpwm_pkg::W_TB:  tb_reg  <= prod_reg[svpwm_pkg::Q15_SHIFT +: 16];
            svpwm_pkg::W_TA:  ta_reg  <= prod_reg[svpwm_pkg::Q15_SHIFT +: 16];
            svpwm_pkg::W_ON:
            begin
                on_a_reg <= on_a;
                on_b_reg <= on_b;
                on_c_reg <= on_c;
            end
            svpwm_pkg::W_CA:  ca_reg <= prod_reg[svpwm_pkg::Q15_SHIFT +: 16];
            svpwm_pkg::W_CB:  cb_reg <= prod_reg[svpwm_pkg::Q15_SHIFT +: 16];
            default:          ;
        endcase
        if (load_out)
            out_data_reg <= {5'b0, sec_reg + 3'd1,
                             prod_reg[svpwm_pkg::Q15_SHIFT +: 16], cb_reg, ca_reg};
    end

endmodule

@@ tb/tb_space_vector_pwm_generator_core.sv @@
module tb_space_vector_pwm_generator_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          PH_BITS     = 16;
    localparam int          LUT_DEPTH   = 256;
    localparam int          NUM_PHASES  = 8;
    localparam int          PHASE_WORDS = 92;
    localparam int          IDLE_CYCLES = 24;
    localparam int          CYCLE_LIMIT = 400000;
    localparam logic [1:0]  REG_SPARE   = 2'd3;

    typedef struct {
        logic [15:0] cmp_a;
        logic [15:0] cmp_b;
        logic [15:0] cmp_c;
        logic [2:0]  sector;
    } pwm_word_t;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_WORD,
        ROW_CHECKED
    } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [1:0]  idx;
        logic [15:0] val;
        logic        tick;
        pwm_word_t   want;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // tick
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;   // compare_a, compare_b, compare_c, sector
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    space_vector_pwm_generator_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow of the block state
    logic [15:0] acc_phase;
    logic [14:0] step_reg;
    logic [15:0] mod_reg;
    logic [15:0] period_reg;
    logic [15:0] sine_lut [0:LUT_DEPTH];

    pwm_word_t   expected_words [$];
    row_t        plan [0:32];
    bit          quiet;
    int          mismatches;
    int          words_sent;
    int          results_seen;
    int          settings_used;
    int          cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_space_vector_pwm_generator_core failed");
            $finish;
        end
    end

    function automatic logic [15:0] quarter_sine(input int unsigned i);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] r;
        int unsigned k;
        x    = (64'(i) * svpwm_pkg::HALF_PI_Q30) / LUT_DEPTH;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (k = 1; k <= 8; k++)
        begin
            term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
                sum = (sum >= term) ? sum - term : 64'd0;
            else
                sum = sum + term;
        end
        r = (sum + 64'd16384) >> 15;
        return (r > 64'd32768) ? svpwm_pkg::ONE_Q15 : r[15:0];
    endfunction

    function automatic logic [63:0] sine_at(input logic [63:0] r);
        logic [63:0] idx;
        idx = (r * 2 * LUT_DEPTH) / (64'd3 << PH_BITS);
        if (idx > LUT_DEPTH)
            idx = LUT_DEPTH;
        return 64'(sine_lut[idx]);
    endfunction

    function automatic logic [15:0] duty_to_compare(input logic [63:0] on);
        logic [63:0] prod;
        if (on > 64'd32768)
            on = 64'd32768;
        prod = (64'(period_reg) * (64'd32768 - on)) >> 15;
        return prod[15:0];
    endfunction

    function automatic pwm_word_t svpwm_compute(input logic [15:0] ph);
        pwm_word_t   w;
        logic [63:0] m;
        logic [63:0] scaled;
        logic [63:0] sec;
        logic [63:0] theta;
        logic [63:0] ta;
        logic [63:0] tb;
        logic [63:0] h;
        logic [63:0] on_a;
        logic [63:0] on_b;
        logic [63:0] on_c;
        m      = (mod_reg > svpwm_pkg::ONE_Q15) ? 64'd32768 : 64'(mod_reg);
        scaled = 64'(ph) * 6;
        sec    = scaled >> PH_BITS;
        if (sec > 5)
            sec = 5;
        theta  = scaled & ((64'd1 << PH_BITS) - 1);
        ta     = (m * sine_at((64'd1 << PH_BITS) - theta)) >> 15;
        tb     = (m * sine_at(theta)) >> 15;
        if (ta > 64'd32768)
            ta = 64'd32768;
        if (ta + tb > 64'd32768)
            tb = 64'd32768 - ta;
        h = (64'd32768 - ta - tb) >> 1;
        case (sec)
            0: begin on_a = ta + tb + h; on_b = tb + h;      on_c = h;           end
            1: begin on_a = ta + h;      on_b = ta + tb + h; on_c = h;           end
            2: begin on_a = h;           on_b = ta + tb + h; on_c = tb + h;      end
            3: begin on_a = h;           on_b = ta + h;      on_c = ta + tb + h; end
            4: begin on_a = tb + h;      on_b = h;           on_c = ta + tb + h; end
            default: begin on_a = ta + tb + h; on_b = h;     on_c = ta + h;      end
        endcase
        w.cmp_a  = duty_to_compare(on_a);
        w.cmp_b  = duty_to_compare(on_b);
        w.cmp_c  = duty_to_compare(on_c);
        w.sector = 3'(sec + 1);
        return w;
    endfunction

    function automatic pwm_word_t pwm_word(input logic [15:0] a, input logic [15:0] b,
                                           input logic [15:0] c, input logic [2:0] s);
        pwm_word_t w;
        w.cmp_a  = a;
        w.cmp_b  = b;
        w.cmp_c  = c;
        w.sector = s;
        return w;
    endfunction

    function automatic row_t cfg_row(input logic [1:0] idx, input logic [15:0] val);
        row_t r;
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.val  = val;
        r.tick = 1'b0;
        r.want = pwm_word(16'd0, 16'd0, 16'd0, 3'd0);
        return r;
    endfunction

    function automatic row_t word_row(input logic tick);
        row_t r;
        r      = cfg_row(svpwm_pkg::REG_PHASE_STEP, 16'd0);
        r.kind = ROW_WORD;
        r.tick = tick;
        return r;
    endfunction

    function automatic row_t checked_row(input logic tick, input pwm_word_t want);
        row_t r;
        r      = word_row(tick);
        r.kind = ROW_CHECKED;
        r.want = want;
        return r;
    endfunction

    task automatic send_word(input logic tick, input logic typed, input pwm_word_t want);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, tick};
        do
            @(posedge clk);
        while (!s_tready);
        if (tick)
            acc_phase = acc_phase + 16'(step_reg);
        expected_words.push_back(typed ? want : svpwm_compute(acc_phase));
        words_sent++;
        @(negedge clk);
    endtask

    // lower valid and wait for every outstanding word, then let the block settle
    task automatic drain(input int extra);
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0)
            @(negedge clk);
        repeat (extra) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            svpwm_pkg::REG_PHASE_STEP: step_reg   = val[14:0];
            svpwm_pkg::REG_MOD_INDEX:  mod_reg    = val;
            svpwm_pkg::REG_PWM_PERIOD: period_reg = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic pick_settings();
        logic [15:0] v;
        drain(IDLE_CYCLES);
        case ($urandom_range(0, 3))
            0: v = 16'h8000;
            1: v = 16'hFFFF;
            default: v = 16'($urandom_range(0, 65535));
        endcase
        write_reg(svpwm_pkg::REG_PHASE_STEP, v);
        case ($urandom_range(0, 4))
            0: v = 16'd0;
            1: v = svpwm_pkg::ONE_Q15;
            2: v = 16'($urandom_range(32769, 65535));
            default: v = 16'($urandom_range(0, 32768));
        endcase
        write_reg(svpwm_pkg::REG_MOD_INDEX, v);
        case ($urandom_range(0, 4))
            0: v = 16'd0;
            1: v = 16'd1;
            2: v = 16'hFFFF;
            default: v = 16'($urandom_range(0, 65535));
        endcase
        write_reg(svpwm_pkg::REG_PWM_PERIOD, v);
        settings_used++;
    endtask

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // result side
    initial
    begin
        int        stall;
        pwm_word_t want;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            results_seen++;
            if (expected_words.size() == 0)
            begin
                $error("result word with nothing expected: %h", m_tdata);
                mismatches++;
            end
            else
            begin
                want = expected_words.pop_front();
                check_field("compare_a", want.cmp_a, m_tdata[15:0]);
                check_field("compare_b", want.cmp_b, m_tdata[31:16]);
                check_field("compare_c", want.cmp_c, m_tdata[47:32]);
                check_field("sector", 16'(want.sector), 16'(m_tdata[50:48]));
            end
            @(negedge clk);
        end
    end

    // stimulus side
    initial
    begin
        int p;
        int n;
        int directed_words;
        s_tvalid   = 1'b0;
        s_tdata    = 8'd0;
        cfg_we     = 1'b0;
        cfg_index  = 2'd0;
        cfg_data   = 16'd0;
        rst_n      = 1'b0;
        quiet      = 1'b0;
        mismatches = 0;
        words_sent = 0;
        results_seen  = 0;
        settings_used = 1;
        cycle_count   = 0;
        acc_phase  = 16'd0;
        step_reg   = svpwm_pkg::PHASE_STEP_RST;
        mod_reg    = svpwm_pkg::MOD_INDEX_RST;
        period_reg = svpwm_pkg::PWM_PERIOD_RST;
        for (n = 0; n <= LUT_DEPTH; n++)
            sine_lut[n] = quarter_sine(n);

        plan = '{
            word_row(1'b0),
            // zero period forces every compare to zero
            cfg_row(svpwm_pkg::REG_PWM_PERIOD, 16'd0),
            checked_row(1'b0, pwm_word(16'd0, 16'd0, 16'd0, 3'd1)),
            // zero index leaves only the zero vector, half period on each leg
            cfg_row(svpwm_pkg::REG_MOD_INDEX, 16'd0),
            cfg_row(svpwm_pkg::REG_PWM_PERIOD, 16'd7500),
            checked_row(1'b0, pwm_word(16'd3750, 16'd3750, 16'd3750, 3'd1)),
            cfg_row(svpwm_pkg::REG_PWM_PERIOD, 16'hFFFF),
            checked_row(1'b1, pwm_word(16'd32767, 16'd32767, 16'd32767, 3'd1)),
            // saturated index, largest step, phase wraps
            cfg_row(svpwm_pkg::REG_MOD_INDEX, 16'hFFFF),
            cfg_row(svpwm_pkg::REG_PHASE_STEP, 16'hFFFF),
            word_row(1'b1), word_row(1'b1), word_row(1'b1), word_row(1'b1),
            word_row(1'b1),
            // one sixth of a turn per word walks the sectors
            cfg_row(svpwm_pkg::REG_MOD_INDEX, 16'h8000),
            cfg_row(svpwm_pkg::REG_PHASE_STEP, 16'd10923),
            word_row(1'b1), word_row(1'b1), word_row(1'b1), word_row(1'b1),
            word_row(1'b1), word_row(1'b1), word_row(1'b1),
            cfg_row(svpwm_pkg::REG_MOD_INDEX, 16'h8001),
            cfg_row(svpwm_pkg::REG_PHASE_STEP, 16'd0),
            word_row(1'b1),
            cfg_row(svpwm_pkg::REG_PWM_PERIOD, 16'd1),
            word_row(1'b0),
            cfg_row(REG_SPARE, 16'h5A5A),
            word_row(1'b1),
            cfg_row(svpwm_pkg::REG_PHASE_STEP, 16'd1),
            word_row(1'b1)
        };

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        foreach (plan[i])
        begin
            case (plan[i].kind)
                ROW_CFG:
                begin
                    drain(IDLE_CYCLES);
                    write_reg(plan[i].idx, plan[i].val);
                    settings_used++;
                end
                ROW_WORD:    send_word(plan[i].tick, 1'b0, plan[i].want);
                default:     send_word(plan[i].tick, 1'b1, plan[i].want);
            endcase
        end
        directed_words = words_sent;

        for (p = 0; p < NUM_PHASES; p++)
        begin
            pick_settings();
            quiet = (p % 3 == 2);
            for (n = 0; n < PHASE_WORDS; n++)
            begin
                if (p == 1 && n == PHASE_WORDS / 2)
                    drain(0);
                send_word($urandom_range(0, 9) != 0, 1'b0, pwm_word(16'd0, 16'd0, 16'd0, 3'd0));
            end
        end
        quiet = 1'b0;

        drain(40);
        $display("covered %0d directed and %0d random words over %0d register settings",
                 directed_words, words_sent - directed_words, settings_used);
        $display("checked %0d result words, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0)
            $display("tb_space_vector_pwm_generator_core passed");
        else
            $display("tb_space_vector_pwm_generator_core failed");
        $finish;
    end

endmodule
